[rtl/cpfc_pkg.sv]
// Package for the capture pixel format converter: types, codes, coefficients, YUV math.
`timescale 1ns / 1ps

package cpfc_pkg;

  // Source format codes held in the mode register
  typedef enum logic [1:0] {
    MODE_GRAY8  = 2'd0,
    MODE_YUV422 = 2'd1,
    MODE_RGB888 = 2'd2,
    MODE_RGB555 = 2'd3
  } src_mode_e;

  // Configuration register indexes
  localparam logic CFG_SOURCE_MODE = 1'b0;
  localparam logic CFG_GRAY_OUTPUT = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // Output queue depth, power of two and at least four
  localparam int FIFO_DEPTH = 8;

  // One result pixel: red in the low byte, last flag on top
  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Fixed-point YUV coefficients, scale 1024
  localparam int NUM_W = 21;
  localparam logic signed [NUM_W-1:0] COEF_RV = 21'sd1404;
  localparam logic signed [NUM_W-1:0] COEF_GV = 21'sd715;
  localparam logic signed [NUM_W-1:0] COEF_GU = 21'sd344;
  localparam logic signed [NUM_W-1:0] COEF_BU = 21'sd1774;
  localparam logic [7:0] Y_MIN      = 8'd16;
  localparam logic [7:0] Y_MAX      = 8'd235;
  localparam logic [7:0] CHROMA_OFS = 8'd128;

  // Scale down by 1024 and clamp to a byte; negatives go to zero either way
  function automatic logic [7:0] clamp_byte(input logic signed [NUM_W-1:0] num);
    logic [7:0] res;
    if (num[NUM_W-1]) begin
      res = 8'd0;
    end else if (num[NUM_W-2:18] != '0) begin
      res = 8'hFF;
    end else begin
      res = num[17:10];
    end
    return res;
  endfunction

  // One YUV pixel; u and v already have the 128 offset removed
  function automatic pixel_t yuv_pixel(input logic [7:0] y,
                                       input logic signed [8:0] u,
                                       input logic signed [8:0] v);
    logic [7:0]              yc;
    logic signed [NUM_W-1:0] sy;
    logic signed [NUM_W-1:0] uw;
    logic signed [NUM_W-1:0] vw;
    pixel_t                  px;
    if (y < Y_MIN) begin
      yc = Y_MIN;
    end else if (y > Y_MAX) begin
      yc = Y_MAX;
    end else begin
      yc = y;
    end
    sy = $signed({3'b000, yc, 10'b0});
    uw = NUM_W'(u);
    vw = NUM_W'(v);
    px.red   = clamp_byte(sy + vw * COEF_RV);
    px.green = clamp_byte(sy - vw * COEF_GV - uw * COEF_GU);
    px.blue  = clamp_byte(sy + uw * COEF_BU);
    px.last  = 1'b0;
    return px;
  endfunction

endpackage

[rtl/capture_pixel_format_converter.sv]
// Top level of the capture pixel format converter: input stage, pixel math, result queue.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata = src_word[23:0], tuser = row_start
//  m_axis   | out       | tdata = {blue, green, red}, tlast = last
//  cfg      | in        | cfg_idx_i 0 source_mode, 1 gray_output
//
// One source word is taken per cycle while s_axis_tready is high. A word accepted
// is held in the input register; from there its pixels (none, one or a YUV pair)
// enter the result queue and show on m_axis behind any pixels queued before them.
// The queue drains one pixel per cycle while m_axis_tready is high; s_axis_tready
// drops once the queue holds more than Depth-4 pixels, so a stalled output holds back the input.
// Reset clears the mode registers, the YUV pair phase and the queue.
`timescale 1ns / 1ps

module capture_pixel_format_converter #(
  parameter int Depth = cpfc_pkg::FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // source word stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,   // [23:0] src_word
  input  logic                            s_axis_tuser,   // [0] row_start
  // pixel stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                            m_axis_tlast,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [cpfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpfc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CntW = $clog2(Depth+1);

  cpfc_pkg::src_mode_e mode_q;
  logic                gray_q;

  logic                s1_valid_q;
  logic [23:0]         s1_word_q;
  logic                s1_row_q;

  logic [15:0]         held_q, held_d;
  logic                phase_q, phase_d;

  logic [1:0]          wr_num;
  cpfc_pkg::pixel_t    px0, px1;
  cpfc_pkg::pixel_t    yuv0, yuv1;
  logic [7:0]          gray_val;
  logic                phase_eff;
  logic signed [8:0]   u_val, v_val;

  logic [CntW-1:0]     q_count;
  cpfc_pkg::pixel_t    q_data;
  logic                s_accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cpfc_pkg::MODE_GRAY8;
      gray_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpfc_pkg::CFG_SOURCE_MODE: mode_q <= cpfc_pkg::src_mode_e'(cfg_data_i[1:0]);
        cpfc_pkg::CFG_GRAY_OUTPUT: gray_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input stage
  assign s_axis_tready = (q_count <= CntW'(Depth - 4));
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_word_q <= s_axis_tdata;
      s1_row_q  <= s_axis_tuser;
    end
  end

  // chroma from the held first word (U) and the current word (V)
  assign u_val = $signed({1'b0, held_q[15:8]}) - $signed({1'b0, cpfc_pkg::CHROMA_OFS});
  assign v_val = $signed({1'b0, s1_word_q[15:8]}) - $signed({1'b0, cpfc_pkg::CHROMA_OFS});
  assign yuv0  = cpfc_pkg::yuv_pixel(held_q[7:0], u_val, v_val);
  assign yuv1  = cpfc_pkg::yuv_pixel(s1_word_q[7:0], u_val, v_val);

  // gray value per source format
  always_comb begin
    case (mode_q)
      cpfc_pkg::MODE_RGB555: gray_val = s1_word_q[14:7];
      default:               gray_val = s1_word_q[7:0];
    endcase
  end

  // pair sequencing and pixel selection
  always_comb begin
    phase_eff = s1_row_q ? 1'b0 : phase_q;
    held_d    = held_q;
    phase_d   = phase_q;
    wr_num    = 2'd0;
    px0       = '0;
    px1       = yuv1;
    px1.last  = 1'b1;
    if (s1_valid_q) begin
      if (mode_q == cpfc_pkg::MODE_YUV422 && !gray_q) begin
        if (!phase_eff) begin
          held_d  = s1_word_q[15:0];
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          wr_num  = 2'd2;
          px0     = yuv0;
        end
      end else begin
        phase_d  = 1'b0;
        wr_num   = 2'd1;
        px0.last = 1'b1;
        if (mode_q == cpfc_pkg::MODE_GRAY8 || gray_q) begin
          px0.red   = gray_val;
          px0.green = gray_val;
          px0.blue  = gray_val;
        end else if (mode_q == cpfc_pkg::MODE_RGB888) begin
          px0.red   = s1_word_q[23:16];
          px0.green = s1_word_q[15:8];
          px0.blue  = s1_word_q[7:0];
        end else begin
          // RGB555 slices overlap on purpose
          px0.red   = s1_word_q[14:7];
          px0.green = s1_word_q[9:2];
          px0.blue  = {s1_word_q[4:0], 3'b000};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      held_q  <= held_d;
      phase_q <= phase_d;
    end
  end

  // result queue
  cpfc_out_fifo #(
    .Depth(Depth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_num_i  (wr_num),
    .wr_px0_i  (px0),
    .wr_px1_i  (px1),
    .count_o   (q_count),
    .rd_valid_o(m_axis_tvalid),
    .rd_ready_i(m_axis_tready),
    .rd_data_o (q_data)
  );

  assign m_axis_tdata = q_data[23:0];
  assign m_axis_tlast = q_data.last;

endmodule

[rtl/cpfc_out_fifo.sv]
// Result queue: takes up to two pixels a cycle, hands out one per transaction.
`timescale 1ns / 1ps

module cpfc_out_fifo #(
  parameter int Depth = cpfc_pkg::FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 wr_num_i,
  input  cpfc_pkg::pixel_t           wr_px0_i,
  input  cpfc_pkg::pixel_t           wr_px1_i,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output logic                       rd_valid_o,
  input  logic                       rd_ready_i,
  output cpfc_pkg::pixel_t           rd_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth+1);

  cpfc_pkg::pixel_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;
  logic [PtrW-1:0]  wr_ptr_nxt;

  assign pop        = rd_valid_o && rd_ready_i;
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(wr_num_i);
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(wr_num_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, one or two writes per cycle
  always_ff @(posedge clk_i) begin
    if (wr_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_px0_i;
    end
    if (wr_num_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= wr_px1_i;
    end
  end

  assign count_o    = count_q;
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

endmodule

[rtl/cpfc_checker.sv]
// Port-level checker for the capture pixel format converter, bound to the top level.
`timescale 1ns / 1ps

module cpfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_we_i,
  input logic [cpfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [cpfc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [1:0] mode_q;
  logic       gray_q;
  logic       single_out;

  // shadow of the configuration as seen on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
      gray_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cpfc_pkg::CFG_SOURCE_MODE) begin
        mode_q <= cfg_data_i[1:0];
      end
      if (cfg_idx_i == cpfc_pkg::CFG_GRAY_OUTPUT) begin
        gray_q <= cfg_data_i[0];
      end
    end
  end

  assign single_out = (mode_q != 2'(cpfc_pkg::MODE_YUV422)) || gray_q;

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output transaction changed");

  // one-pixel modes mark every pixel as last
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && single_out |-> m_axis_tlast)
    else $error("single-result mode gave a pixel without last");

  // gray source or gray output repeats one value on all channels
  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == 2'(cpfc_pkg::MODE_GRAY8) || gray_q) |->
      m_axis_tdata[7:0] == m_axis_tdata[15:8] && m_axis_tdata[7:0] == m_axis_tdata[23:16])
    else $error("gray pixel with differing channels");

  // a YUV pair: once the first pixel, without last, is taken, the output stays valid for the second
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second pixel of a pair did not follow");

  // input only holds off while pixels are queued
  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty result queue");

endmodule

bind capture_pixel_format_converter cpfc_checker u_cpfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i)
);

[dv/testbench.sv]
// Self-checking testbench for the capture pixel format converter against a shadow model.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int          RAND_ITEMS  = 1750;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE      = 8;

  typedef struct {
    logic [23:0] word;
    logic        row;
  } src_item_t;

  // DUT signals, all inputs known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [23:0] src_word
  logic        s_axis_tuser  = 1'b0;  // [0] row_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // [7:0] red, [15:8] green, [23:16] blue
  logic        m_axis_tlast;
  logic                            cfg_we_i   = 1'b0;
  logic [cpfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [cpfc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // Stimulus and scoreboard state
  src_item_t          src_items_q[$];
  cpfc_pkg::pixel_t   pixels_due_q[$];
  int                 error_cnt   = 0;
  int unsigned        cycle_cnt   = 0;
  bit                 gaps_on     = 1'b1;
  bit                 hold_start  = 1'b0;
  int                 src_gap     = 0;
  int                 sink_stall  = 0;
  int                 sink_hold   = 0;

  // Shadow copy of the converter state
  cpfc_pkg::src_mode_e fmt_mode   = cpfc_pkg::MODE_GRAY8;
  logic                gray_sel   = 1'b0;
  logic [15:0]         held_word  = '0;
  logic                pair_phase = 1'b0;

  capture_pixel_format_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Chroma byte biased toward the extremes
  function automatic logic [7:0] chroma_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      return 8'h00;
    end else if (r < 4) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] sat_byte(int x);
    if (x < 0) begin
      return 8'd0;
    end else if (x > 255) begin
      return 8'd255;
    end
    return 8'(x);
  endfunction

  // One YUV pixel with luma clamped to video range; / truncates toward zero
  function automatic cpfc_pkg::pixel_t yuv_to_rgb(logic [7:0] y, int u, int v, logic last);
    int               yl;
    int               ys;
    cpfc_pkg::pixel_t px;
    yl = int'(y);
    if (yl < 16) begin
      yl = 16;
    end else if (yl > 235) begin
      yl = 235;
    end
    ys = yl * 1024;
    px.red   = sat_byte((ys + 1404 * v) / 1024);
    px.green = sat_byte((ys - 715 * v - 344 * u) / 1024);
    px.blue  = sat_byte((ys + 1774 * u) / 1024);
    px.last  = last;
    return px;
  endfunction

  // Expected pixels for one accepted source word
  task automatic convert_word(input logic [23:0] word, input logic row);
    int               u;
    int               v;
    cpfc_pkg::pixel_t px;
    if (row) begin
      pair_phase = 1'b0;
    end
    if (fmt_mode == cpfc_pkg::MODE_YUV422 && !gray_sel) begin
      if (!pair_phase) begin
        held_word  = word[15:0];
        pair_phase = 1'b1;
      end else begin
        pair_phase = 1'b0;
        u = int'(held_word[15:8]) - 128;
        v = int'(word[15:8]) - 128;
        pixels_due_q.push_back(yuv_to_rgb(held_word[7:0], u, v, 1'b0));
        pixels_due_q.push_back(yuv_to_rgb(word[7:0], u, v, 1'b1));
      end
    end else begin
      pair_phase = 1'b0;
      case (fmt_mode)
        cpfc_pkg::MODE_GRAY8, cpfc_pkg::MODE_YUV422: begin
          px.red = word[7:0];
          px.green = word[7:0];
          px.blue = word[7:0];
        end
        cpfc_pkg::MODE_RGB888: begin
          px.red   = gray_sel ? word[7:0] : word[23:16];
          px.green = gray_sel ? word[7:0] : word[15:8];
          px.blue  = word[7:0];
        end
        default: begin
          // RGB555 slices overlap
          px.red   = word[14:7];
          px.green = gray_sel ? word[14:7] : word[9:2];
          px.blue  = gray_sel ? word[14:7] : {word[4:0], 3'b000};
        end
      endcase
      px.last = 1'b1;
      pixels_due_q.push_back(px);
    end
  endtask

  // Source driver
  always @(posedge clk_i) begin : src_drive
    bit busy;
    src_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        convert_word(s_axis_tdata, s_axis_tuser);
        busy = 1'b0;
      end
      if (!busy) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (src_items_q.size() > 0) begin
          item = src_items_q.pop_front();
          s_axis_tdata  <= item.word;
          s_axis_tuser  <= item.row;
          s_axis_tvalid <= 1'b1;
          src_gap = gaps_on ? idle_len() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: pixel %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    error_cnt++;
  endtask

  // Pixel monitor and sink backpressure
  always @(posedge clk_i) begin : pix_check
    cpfc_pkg::pixel_t got;
    cpfc_pkg::pixel_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata};
        if (pixels_due_q.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %0h", $time, got);
          error_cnt++;
        end else begin
          want = pixels_due_q.pop_front();
          if (got.red !== want.red) report("red", want.red, got.red);
          if (got.green !== want.green) report("green", want.green, got.green);
          if (got.blue !== want.blue) report("blue", want.blue, got.blue);
          if (got.last !== want.last) report("last", 8'(want.last), 8'(got.last));
        end
      end
      if (hold_start) begin
        sink_hold = HOLD_CYCLES;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall = gaps_on ? idle_len() : 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL capture_pixel_format_converter");
      $finish;
    end
  end

  task automatic push_item(input logic [23:0] word, input logic row);
    src_item_t item;
    item.word = word;
    item.row  = row;
    src_items_q.push_back(item);
  endtask

  // Wait until every word is taken and every pixel has come out
  task automatic drain_all();
    while (src_items_q.size() != 0 || s_axis_tvalid || pixels_due_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [cpfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cpfc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == cpfc_pkg::CFG_SOURCE_MODE) begin
      fmt_mode = cpfc_pkg::src_mode_e'(val);
    end else begin
      gray_sel = val[0];
    end
  endtask

  // Gray flag written with a random spare bit on top
  task automatic set_format(input cpfc_pkg::src_mode_e mode, input logic gray);
    write_reg(cpfc_pkg::CFG_SOURCE_MODE, mode);
    write_reg(cpfc_pkg::CFG_GRAY_OUTPUT, {1'($urandom), gray});
    @(negedge clk_i);
  endtask

  task automatic long_hold();
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
  endtask

  initial begin : stimulus
    int                  sent;
    int                  p;
    int                  n;
    int                  r;
    cpfc_pkg::src_mode_e mode;
    logic                gray;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: gray8 ignores the gray flag and the upper bits
    gaps_on = 1'b0;
    set_format(cpfc_pkg::MODE_GRAY8, 1'b0);
    push_item(24'h000000, 1'b0);
    push_item(24'hFFFFFF, 1'b1);
    push_item(24'hA55A3C, 1'b0);
    drain_all();
    set_format(cpfc_pkg::MODE_GRAY8, 1'b1);
    push_item(24'h00007F, 1'b0);
    drain_all();
    // RGB888 color and gray
    set_format(cpfc_pkg::MODE_RGB888, 1'b0);
    push_item(24'hFF0000, 1'b0);
    push_item(24'h00FF00, 1'b0);
    push_item(24'h0000FF, 1'b0);
    push_item(24'h123456, 1'b1);
    drain_all();
    set_format(cpfc_pkg::MODE_RGB888, 1'b1);
    push_item(24'hABCDEF, 1'b0);
    drain_all();
    // RGB555 overlapping slices, bit 15 unused
    set_format(cpfc_pkg::MODE_RGB555, 1'b0);
    push_item(24'h007FFF, 1'b0);
    push_item(24'hFF8000, 1'b0);
    push_item(24'h005555, 1'b1);
    drain_all();
    set_format(cpfc_pkg::MODE_RGB555, 1'b1);
    push_item(24'h002AAA, 1'b0);
    drain_all();
    // YUV422 with gray output gives the Y byte, one pixel per word
    set_format(cpfc_pkg::MODE_YUV422, 1'b1);
    push_item(24'h00FFFF, 1'b0);
    push_item(24'hFF1234, 1'b1);
    drain_all();
    // YUV422 color: extreme luma and chroma, neutral chroma, row start mid-pair
    set_format(cpfc_pkg::MODE_YUV422, 1'b0);
    push_item(24'h000000, 1'b1);
    push_item(24'hFFFFFF, 1'b0);
    push_item(24'h008080, 1'b1);
    push_item(24'h008080, 1'b0);
    push_item(24'h00FF10, 1'b1);
    push_item(24'h0000EB, 1'b1);
    push_item(24'h0020C8, 1'b0);
    push_item(24'h004050, 1'b1);
    drain_all();
    // Config change mid-pair: a non-pairing word clears the phase
    set_format(cpfc_pkg::MODE_YUV422, 1'b1);
    push_item(24'h001234, 1'b0);
    drain_all();
    set_format(cpfc_pkg::MODE_YUV422, 1'b0);
    push_item(24'h006070, 1'b0);
    drain_all();
    // Writes alone keep the phase, so the next word completes the pair
    set_format(cpfc_pkg::MODE_GRAY8, 1'b0);
    set_format(cpfc_pkg::MODE_YUV422, 1'b0);
    push_item(24'h009030, 1'b0);
    drain_all();

    // Random phases, each with its own format; YUV color gets extra weight
    sent = 0;
    p = 0;
    while (sent < RAND_ITEMS) begin
      if (p < 8) begin
        mode = cpfc_pkg::src_mode_e'(p % 4);
        gray = 1'((p / 4) % 2);
      end else if ($urandom_range(0, 9) < 4) begin
        mode = cpfc_pkg::MODE_YUV422;
        gray = 1'b0;
      end else begin
        mode = cpfc_pkg::src_mode_e'($urandom_range(0, 3));
        gray = 1'($urandom);
      end
      set_format(mode, gray);
      gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 150);
      for (int i = 0; i < n; i++) begin
        if (mode == cpfc_pkg::MODE_YUV422 && !gray) begin
          r = $urandom_range(0, 99);
          if (r < 85) begin
            // well-formed pair with random content
            push_item({8'($urandom), chroma_byte(), 8'($urandom)}, 1'($urandom));
            push_item({8'($urandom), chroma_byte(), 8'($urandom)}, 1'b0);
            i++;
          end else if (r < 93) begin
            push_item(24'($urandom), 1'b1);
          end else begin
            push_item(24'($urandom), 1'b0);
          end
        end else begin
          push_item(24'($urandom), 1'($urandom));
        end
      end
      sent += src_items_q.size();
      // sink holds off long enough to fill the queue and stall the source
      if (p == 1 || p == 3 || p == 10) begin
        long_hold();
      end
      drain_all();
      p++;
    end

    drain_all();
    if (error_cnt == 0) begin
      $display("PASS capture_pixel_format_converter");
    end else begin
      $display("FAIL capture_pixel_format_converter");
    end
    $finish;
  end

endmodule
